@@ hdl/nearest_palette_color_search_top_macros.svh @@
// Assertion macros for the palette search block.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define NPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("npcs: same-cycle check failed");
// next-cycle implication
`define NPCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("npcs: next-cycle check failed");
`else
`define NPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NPCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/npcs_pkg.sv @@
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int COLOR_W = 8;
    localparam int IN_COLOR_W = 16;
    localparam int PIX_W = 32;
    localparam int DIST_W = 18;
    localparam int CNT_W = 9;
    localparam int SQ_W = 2 * COLOR_W;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [PIX_W-1:0]   pix;
    } t_entry;

endpackage

@@ hdl/npcs_dist.sv @@
`timescale 1ns / 1ps

// Squared RGB distance stage, one entry per cycle, registered output.
module npcs_dist #(
    parameter int IDX_W = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_flush,
    input  logic                           i_valid,
    input  logic [IDX_W-1:0]               i_idx,
    input  npcs_pkg::t_entry               i_entry,
    input  logic [npcs_pkg::COLOR_W-1:0]   i_query_red,
    input  logic [npcs_pkg::COLOR_W-1:0]   i_query_green,
    input  logic [npcs_pkg::COLOR_W-1:0]   i_query_blue,
    output logic                           o_valid,
    output logic [IDX_W-1:0]               o_idx,
    output logic [npcs_pkg::DIST_W-1:0]    o_dist,
    output logic [npcs_pkg::PIX_W-1:0]     o_pix
);

    logic [npcs_pkg::COLOR_W-1:0] dr, dg, db;
    logic [npcs_pkg::SQ_W-1:0]    sr, sg, sb;
    logic [npcs_pkg::DIST_W-1:0]  n_dist;

    logic                          r_valid;
    logic [IDX_W-1:0]              r_idx;
    logic [npcs_pkg::DIST_W-1:0]   r_dist;
    logic [npcs_pkg::PIX_W-1:0]    r_pix;

    always_comb begin
        dr = (i_query_red > i_entry.red) ? i_query_red - i_entry.red
                                         : i_entry.red - i_query_red;
        dg = (i_query_green > i_entry.green) ? i_query_green - i_entry.green
                                             : i_entry.green - i_query_green;
        db = (i_query_blue > i_entry.blue) ? i_query_blue - i_entry.blue
                                           : i_entry.blue - i_query_blue;
        sr = npcs_pkg::SQ_W'(dr) * npcs_pkg::SQ_W'(dr);
        sg = npcs_pkg::SQ_W'(dg) * npcs_pkg::SQ_W'(dg);
        sb = npcs_pkg::SQ_W'(db) * npcs_pkg::SQ_W'(db);
        n_dist = npcs_pkg::DIST_W'(sr) + npcs_pkg::DIST_W'(sg) + npcs_pkg::DIST_W'(sb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid && !i_flush;
            r_idx   <= i_idx;
            r_dist  <= n_dist;
            r_pix   <= i_entry.pix;
        end
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_dist  = r_dist;
    assign o_pix   = r_pix;

endmodule

@@ hdl/nearest_palette_color_search_top.sv @@
// Nearest palette color search: a query over N entries (N = entry_count,
// capped at TABLE_DEPTH) is busy until an exact match or the last entry,
// then strobes its result; if N is 0 it strobes in the cycle after accept.
// Throughput is bound by the single palette read port: one entry per cycle.
// Reset (sync, active low) clears the sequencer and entry_count; palette
// contents are undefined until written. Results cannot be stalled.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_top_macros.svh"

module nearest_palette_color_search_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [7:0]                    i_entry_index,
    input  logic [npcs_pkg::IN_COLOR_W-1:0] i_entry_red,
    input  logic [npcs_pkg::IN_COLOR_W-1:0] i_entry_green,
    input  logic [npcs_pkg::IN_COLOR_W-1:0] i_entry_blue,
    input  logic [npcs_pkg::PIX_W-1:0]    i_entry_pixel,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_query_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_query_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_query_blue,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [npcs_pkg::CNT_W-1:0]    i_cfg_wdata,
    // result strobe
    output logic                          o_valid,
    output logic [npcs_pkg::PIX_W-1:0]    o_pixel,
    output logic [7:0]                    o_best_index,
    output logic [npcs_pkg::DIST_W-1:0]   o_best_distance,
    output logic                          o_empty_res
);

    localparam int AW = $clog2(TABLE_DEPTH);      // palette address width
    localparam int CW = $clog2(TABLE_DEPTH + 1);  // scan count, can hold TABLE_DEPTH

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // palette storage: one write port (write items), one registered read port (scan)
    npcs_pkg::t_entry r_mem [TABLE_DEPTH];
    npcs_pkg::t_entry r_rd_data;

    t_state                          r_state;
    logic [npcs_pkg::CNT_W-1:0]      r_entry_count;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_issue;
    logic                            r_rd_vld;
    logic [AW-1:0]                   r_rd_idx;
    logic [npcs_pkg::COLOR_W-1:0]    r_qr, r_qg, r_qb;

    // running best of the scan
    logic                            r_found;
    logic [AW-1:0]                   r_best_idx;
    logic [npcs_pkg::DIST_W-1:0]     r_best_dist;
    logic [npcs_pkg::PIX_W-1:0]      r_best_pix;

    // result register
    logic                            r_valid;
    logic [npcs_pkg::PIX_W-1:0]      r_pixel;
    logic [7:0]                      r_out_idx;
    logic [npcs_pkg::DIST_W-1:0]     r_out_dist;
    logic                            r_empty;

    logic                            write_acc, query_acc, idx_ok;
    logic [CW-1:0]                   scan_count;
    logic                            issue_more, scan_done, flush;
    logic [AW-1:0]                   rd_addr;

    logic                            dist_vld;
    logic [AW-1:0]                   dist_idx;
    logic [npcs_pkg::DIST_W-1:0]     dist_val;
    logic [npcs_pkg::PIX_W-1:0]      dist_pix;
    logic                            take;

    logic                            n_found;
    logic [AW-1:0]                   n_best_idx;
    logic [npcs_pkg::DIST_W-1:0]     n_best_dist;
    logic [npcs_pkg::PIX_W-1:0]      n_best_pix;

    assign busy      = (r_state != ST_IDLE);
    assign write_acc = start && !busy && (i_opcode == npcs_pkg::OP_WRITE);
    assign query_acc = start && !busy && (i_opcode == npcs_pkg::OP_QUERY);
    // writes past the table are dropped
    assign idx_ok    = (32'(i_entry_index) < 32'(TABLE_DEPTH));
    // entry_count above the table depth scans the whole table
    assign scan_count = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                : CW'(r_entry_count);
    assign rd_addr    = r_issue[AW-1:0];
    assign issue_more = (r_issue < r_count);

    // strict less-than keeps the first of a tie
    assign take = dist_vld && (!r_found || (dist_val < r_best_dist));

    always_comb begin
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_best_pix  = r_best_pix;
        if (take) begin
            n_found     = 1'b1;
            n_best_idx  = dist_idx;
            n_best_dist = dist_val;
            n_best_pix  = dist_pix;
        end
    end

    // done on an exact match, or once every entry has drained through compare
    assign scan_done = (r_state == ST_SCAN) &&
                       ((dist_vld && (dist_val == '0)) ||
                        (!issue_more && !r_rd_vld && !dist_vld));
    // drop in-flight entries after the scan ends
    assign flush = (r_state != ST_SCAN) || scan_done;

    always_ff @(posedge i_clk) begin
        if (write_acc && idx_ok) begin
            r_mem[AW'(i_entry_index)] <= '{
                red:   i_entry_red[npcs_pkg::IN_COLOR_W-1 -: npcs_pkg::COLOR_W],
                green: i_entry_green[npcs_pkg::IN_COLOR_W-1 -: npcs_pkg::COLOR_W],
                blue:  i_entry_blue[npcs_pkg::IN_COLOR_W-1 -: npcs_pkg::COLOR_W],
                pix:   i_entry_pixel
            };
        end
        r_rd_data <= r_mem[rd_addr];
    end

    npcs_dist #(
        .IDX_W (AW)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_flush       (flush),
        .i_valid       (r_rd_vld),
        .i_idx         (r_rd_idx),
        .i_entry       (r_rd_data),
        .i_query_red   (r_qr),
        .i_query_green (r_qg),
        .i_query_blue  (r_qb),
        .o_valid       (dist_vld),
        .o_idx         (dist_idx),
        .o_dist        (dist_val),
        .o_pix         (dist_pix)
    );

    // sequencer, scan bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_valid       <= 1'b0;
            r_issue       <= '0;
            r_count       <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (query_acc) begin
                        r_qr <= i_query_red;
                        r_qg <= i_query_green;
                        r_qb <= i_query_blue;
                        if (r_entry_count == '0) begin
                            // empty palette: answer at once
                            r_valid    <= 1'b1;
                            r_empty    <= 1'b1;
                            r_pixel    <= '0;
                            r_out_idx  <= '0;
                            r_out_dist <= '0;
                        end else begin
                            r_state <= ST_SCAN;
                            r_count <= scan_count;
                            r_issue <= '0;
                            r_found <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    r_found     <= n_found;
                    r_best_idx  <= n_best_idx;
                    r_best_dist <= n_best_dist;
                    r_best_pix  <= n_best_pix;
                    r_rd_idx    <= rd_addr;
                    if (issue_more) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (scan_done) begin
                        r_state    <= ST_IDLE;
                        r_rd_vld   <= 1'b0;
                        r_valid    <= 1'b1;
                        r_empty    <= 1'b0;
                        r_pixel    <= n_best_pix;
                        r_out_idx  <= 8'(n_best_idx);
                        r_out_dist <= n_best_dist;
                    end else begin
                        r_rd_vld <= issue_more;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_pixel         = r_pixel;
    assign o_best_index    = r_out_idx;
    assign o_best_distance = r_out_dist;
    assign o_empty_res     = r_empty;

    // checks
    `NPCS_ASSERT_IMP(a_issue_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_issue <= r_count)
    `NPCS_ASSERT_NXT(a_done_result, i_clk, i_rst_n, scan_done, o_valid && !o_empty_res)
    `NPCS_ASSERT_IMP(a_idle_drained, i_clk, i_rst_n, r_state == ST_IDLE && $past(r_state == ST_IDLE), !r_rd_vld && !dist_vld)
    `NPCS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && o_empty_res, o_pixel == '0 && o_best_distance == '0)

endmodule
